/* design/debounced_chord_keypad_entry_defines.svh */
// ----------------------------------------------------------------------------
// Debounced chord keypad entry: assertion macros
// Shared macros for the concurrent checks of the keypad entry block.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_CHORD_KEYPAD_ENTRY_DEFINES_SVH
`define DEBOUNCED_CHORD_KEYPAD_ENTRY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCKE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DCKE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dcke_pkg.sv */
// ----------------------------------------------------------------------------
// Debounced chord keypad entry: package
// Payload types, command codes and constants shared by the block's modules.
// ----------------------------------------------------------------------------
package dcke_pkg;

    localparam int unsigned ID_W        = 29;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [2:0] PAT_NONE      = 3'h7;
    localparam logic [2:0] PAT_ONE       = 3'h6;
    localparam logic [2:0] PAT_TWO       = 3'h5;
    localparam logic [2:0] PAT_THREE     = 3'h3;
    localparam logic [2:0] PAT_TWO_THREE = 3'h1;

    localparam logic [7:0] LETTER_LOW  = 8'd65;
    localparam logic [7:0] LETTER_HIGH = 8'd90;
    localparam logic [7:0] BLANK       = 8'd95;

    localparam logic [ID_W-1:0] ID_MAX_STD = 29'h7FF;
    localparam logic [ID_W-1:0] ID_MAX_EXT = 29'h1FFFFFFF;
    localparam logic [ID_W-1:0] ID_RESET   = 29'd1;

    localparam logic [7:0] THRESHOLD_RESET = 8'd2;

    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_UP   = 3'd1;
    localparam logic [2:0] ACT_DOWN = 3'd2;
    localparam logic [2:0] ACT_NEXT = 3'd3;
    localparam logic [2:0] ACT_RX   = 3'd4;
    localparam logic [2:0] ACT_TX   = 3'd5;

    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_EXTENDED  = 2'd1;
    localparam logic [1:0] CFG_TX_START  = 2'd2;
    localparam logic [1:0] CFG_RX_START  = 2'd3;

    typedef struct packed {
        logic button_one;
        logic button_two;
        logic button_three;
        logic rx_busy;
    } in_t;

    typedef struct packed {
        logic [2:0]      action;
        logic [1:0]      position;
        logic [7:0]      shown_first;
        logic [7:0]      shown_second;
        logic [7:0]      shown_third;
        logic            send_frame;
        logic [7:0]      frame_byte_a;
        logic [7:0]      frame_byte_b;
        logic [7:0]      frame_byte_c;
        logic [ID_W-1:0] transmit_id;
        logic [ID_W-1:0] receive_id;
        logic            rx_rearm;
    } out_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] action;
    } cmd_beat_t;

endpackage

/* design/dcke_front.sv */
// ----------------------------------------------------------------------------
// Debounced chord keypad entry: front end
// Debounces each poll, detects settled changes and classifies them into
// commands for the back end.
// ----------------------------------------------------------------------------
module dcke_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  dcke_pkg::in_t       in_data,
    input  logic [7:0]          threshold,
    output dcke_pkg::cmd_beat_t push
);
    import dcke_pkg::*;

    logic [2:0] prev_reg, prev_next;
    logic [2:0] settled_reg, settled_next;
    logic [2:0] prior_reg, prior_next;
    logic [7:0] count_reg, count_next;
    logic [2:0] cur;
    logic [7:0] count_inc;
    logic       accept;
    logic       settle;
    logic [2:0] action;

    assign accept    = in_valid && !in_stall;
    assign cur       = {~in_data.button_three, ~in_data.button_two, ~in_data.button_one};
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        prev_next    = prev_reg;
        settled_next = settled_reg;
        prior_next   = prior_reg;
        count_next   = count_reg;
        settle       = 1'b0;
        action       = ACT_NONE;
        if (accept)
        begin
            prev_next = cur;
            if (settled_reg != cur && prev_reg == cur)
            begin
                count_next = count_inc;
                if (count_inc > threshold)
                begin
                    settled_next = cur;
                    count_next   = 8'd0;
                    settle       = 1'b1;
                end
            end
            else
            begin
                count_next = 8'd0;
            end
            if (settle)
            begin
                prior_next = cur;
                if (cur == PAT_ONE && prior_reg == PAT_NONE)
                begin
                    action = ACT_UP;
                end
                else if (cur == PAT_TWO && prior_reg == PAT_NONE)
                begin
                    action = ACT_DOWN;
                end
                else if (cur == PAT_THREE && prior_reg == PAT_NONE)
                begin
                    action = ACT_NEXT;
                end
                else if (cur == PAT_TWO_THREE && prior_reg == PAT_THREE)
                begin
                    action = in_data.rx_busy ? ACT_NONE : ACT_RX;
                end
                else if (cur == PAT_TWO_THREE && prior_reg == PAT_TWO)
                begin
                    action = ACT_TX;
                end
            end
        end
    end

    assign push.valid  = action != ACT_NONE;
    assign push.action = action;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= PAT_NONE;
            settled_reg <= PAT_NONE;
            prior_reg   <= PAT_NONE;
            count_reg   <= 8'd0;
        end
        else
        begin
            prev_reg    <= prev_next;
            settled_reg <= settled_next;
            prior_reg   <= prior_next;
            count_reg   <= count_next;
        end
    end

endmodule

/* design/dcke_queue.sv */
// ----------------------------------------------------------------------------
// Debounced chord keypad entry: command queue
// Short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module dcke_queue #(
    parameter int unsigned DEPTH = dcke_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dcke_pkg::cmd_beat_t push,
    input  logic                pop,
    output dcke_pkg::cmd_beat_t head,
    output logic                full
);
    import dcke_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [2:0]       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head.valid = count_reg != '0;
    assign head.action = entry_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.action;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/dcke_back.sv */
// ----------------------------------------------------------------------------
// Debounced chord keypad entry: back end
// Carries out letter, position, frame and identifier commands and holds the
// result beat in an output register.
// ----------------------------------------------------------------------------
module dcke_back (
    input  logic                clk,
    input  logic                rst_n,
    input  dcke_pkg::cmd_beat_t head,
    output logic                pop,
    input  logic                extended,
    output logic                out_valid,
    input  logic                out_stall,
    output dcke_pkg::out_t      out_data
);
    import dcke_pkg::*;

    function automatic logic [7:0] letter_up(input logic [7:0] v);
        return (v >= LETTER_HIGH) ? LETTER_LOW : v + 8'd1;
    endfunction

    function automatic logic [7:0] letter_down(input logic [7:0] v);
        return (v <= LETTER_LOW) ? LETTER_HIGH : v - 8'd1;
    endfunction

    function automatic logic [ID_W-1:0] step_id(input logic [ID_W-1:0] id, input logic ext);
        logic [ID_W:0] v;
        logic [ID_W:0] limit;
        v     = {1'b0, id} + 1'b1;
        limit = {1'b0, ext ? ID_MAX_EXT : ID_MAX_STD};
        return (v > limit) ? ID_RESET : v[ID_W-1:0];
    endfunction

    logic [1:0]      pos_reg, pos_next;
    logic [7:0]      letters_reg [3];
    logic [7:0]      letters_next [3];
    logic [7:0]      frame_reg [3];
    logic [7:0]      frame_next [3];
    logic [ID_W-1:0] tx_reg, tx_next;
    logic [ID_W-1:0] rx_reg, rx_next;
    logic            out_valid_reg;
    out_t            out_data_reg;
    out_t            result;
    logic [1:0]      idx;
    logic            do_next;

    assign pop       = head.valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign do_next   = head.action inside {ACT_NEXT, ACT_RX};

    always_comb
    begin
        case (pos_reg)
            2'd2:    idx = 2'd1;
            2'd3:    idx = 2'd2;
            default: idx = 2'd0;
        endcase
    end

    always_comb
    begin
        pos_next     = pos_reg;
        letters_next = letters_reg;
        frame_next   = frame_reg;
        tx_next      = tx_reg;
        rx_next      = rx_reg;
        case (head.action)
            ACT_UP:
            begin
                letters_next[idx] = letter_up(letters_reg[idx]);
            end
            ACT_DOWN:
            begin
                letters_next[idx] = letter_down(letters_reg[idx]);
            end
            ACT_RX:
            begin
                rx_next = step_id(rx_reg, extended);
            end
            ACT_TX:
            begin
                tx_next           = step_id(tx_reg, extended);
                letters_next[idx] = letter_down(letters_reg[idx]);
            end
            default:
            begin
            end
        endcase
        if (do_next)
        begin
            if (pos_reg == 2'd3)
            begin
                frame_next   = letters_reg;
                letters_next = '{LETTER_LOW, LETTER_LOW, LETTER_LOW};
                pos_next     = 2'd1;
            end
            else if (pos_reg == 2'd0)
            begin
                pos_next = 2'd2;
            end
            else
            begin
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        result.action       = head.action;
        result.position     = pos_next;
        result.shown_first  = letters_next[0];
        result.shown_second = (pos_next >= 2'd2) ? letters_next[1] : BLANK;
        result.shown_third  = (pos_next == 2'd3) ? letters_next[2] : BLANK;
        result.send_frame   = do_next;
        result.frame_byte_a = frame_next[0];
        result.frame_byte_b = frame_next[1];
        result.frame_byte_c = frame_next[2];
        result.transmit_id  = tx_next;
        result.receive_id   = rx_next;
        result.rx_rearm     = head.action == ACT_RX;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= 2'd1;
            letters_reg   <= '{LETTER_LOW, LETTER_LOW, LETTER_LOW};
            frame_reg     <= '{8'd0, 8'd0, 8'd0};
            tx_reg        <= ID_RESET;
            rx_reg        <= ID_RESET;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
                letters_reg   <= letters_next;
                frame_reg     <= frame_next;
                tx_reg        <= tx_next;
                rx_reg        <= rx_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* design/debounced_chord_keypad_entry.sv */
// ----------------------------------------------------------------------------
// Debounced chord keypad entry
// Debounces three-button polls, decodes presses and chords, and edits a
// three-letter message with transmit and receive identifiers.
// ----------------------------------------------------------------------------
//  channel   direction  beat      handshake
//  in        input      in_t      in_valid / in_stall
//  out       output     out_t     out_valid / out_stall
//  cfg       input      29 bits   cfg_write, cfg_index
//
// One poll is taken every cycle while the command queue has room.
// A command that a poll produces passes the command queue and then the back
// end's output register on its way to the output.
// Reset sets all but the queue entries and output data; identifiers start at 1.
// A stalled output fills the queue, and only then is the input stalled.
// ----------------------------------------------------------------------------
module debounced_chord_keypad_entry #(
    parameter int unsigned QUEUE_DEPTH = dcke_pkg::QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  dcke_pkg::in_t             in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output dcke_pkg::out_t            out_data,
    input  logic                      cfg_write,
    input  logic [1:0]                cfg_index,
    input  logic [dcke_pkg::ID_W-1:0] cfg_data
);
    import dcke_pkg::*;

    `include "debounced_chord_keypad_entry_defines.svh"

    logic [7:0] threshold_reg;
    logic       extended_reg;
    cmd_beat_t  push;
    cmd_beat_t  head;
    logic       pop;
    logic       full;

    assign in_stall = full;

    // Writes to the start values fall into the default branch and are ignored,
    // so they never reach the identifier counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            extended_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data[7:0];
                CFG_EXTENDED:  extended_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    dcke_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .threshold (threshold_reg),
        .push      (push)
    );

    dcke_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (full)
    );

    dcke_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .extended  (extended_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `DCKE_ASSERT_NOW(a_send_matches_action, out_valid,
        out_data.send_frame == (out_data.action == ACT_NEXT || out_data.action == ACT_RX),
        "send flag disagrees with action")
    `DCKE_ASSERT_NOW(a_rearm_only_rx, out_valid,
        out_data.rx_rearm == (out_data.action == ACT_RX),
        "rearm flag disagrees with action")
    `DCKE_ASSERT_NOW(a_position_range, out_valid,
        out_data.position != 2'd0 && out_data.action != ACT_NONE,
        "result beat with bad position or no action")
    `DCKE_ASSERT_NEXT(a_no_drop_on_stall, out_valid && out_stall,
        out_valid, "result beat dropped under stall")

endmodule
